// ----- design/swr_pkg.sv -----
// Shared types and constants of the stereo wavetable resampler.
// Depends on nothing; every other file but swr_queue imports it.
package swr_pkg;

    // table geometry and sample format
    localparam int POS_W       = 16;
    localparam int SIZE_W      = POS_W + 1;
    localparam int TABLE_DEPTH = 1 << POS_W;
    localparam int SAMPLE_W    = 16;

    // interpolator datapath widths: multiplicand and unsaturated sum
    localparam int MULT_W = 21;
    localparam int SUM_W  = 22;

    // clamp bounds of the table size register
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(TABLE_DEPTH);

    // saturation bounds
    localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] Y_MIN = SUM_W'(-(2 ** (SAMPLE_W - 1)));

    // input commands
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD  = 2'd0;
    localparam cmd_t CMD_START = 2'd1;
    localparam cmd_t CMD_TICK  = 2'd2;

    // register indexes of the config port
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_INTERP = 2'd0;
    localparam reg_idx_t REG_SIZE   = 2'd1;
    localparam reg_idx_t REG_STEREO = 2'd2;

    // operation handed from front to back: table load or tick positions
    typedef struct packed {
        logic             is_tick;
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
    } swr_op_t;

    // one stereo result word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       clipped;
    } swr_res_t;

endpackage

// ----- design/swr_queue.sv -----
// Small synchronous queue used between front and back and on the result side.
// Depends on nothing but its parameters.
module swr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/swr_front.sv -----
// Front end: accepts items, keeps the read positions and the fraction,
// reduces positions modulo the table size bit-serially. Uses swr_pkg.
module swr_front #(
    parameter int FRAC_W = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  swr_pkg::cmd_t               cmd,
    input  logic [swr_pkg::POS_W-1:0]   table_addr,
    input  logic signed [15:0]          table_data,
    input  logic [swr_pkg::POS_W-1:0]   start_pos,
    input  logic [swr_pkg::POS_W-1:0]   step_int,
    input  logic [15:0]                 step_frac,
    input  logic                        stereo,
    input  logic [swr_pkg::SIZE_W-1:0]  eff_size,
    input  logic                        iq_full,
    output logic                        iq_push,
    output swr_pkg::swr_op_t            iq_op,
    output logic [FRAC_W-1:0]           iq_frac
);

    import swr_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_CHECK = 4'b0010,
        F_REM   = 4'b0100,
        F_STEP  = 4'b1000
    } fstate_t;

    localparam int CNT_W = $clog2(POS_W);
    localparam logic [CNT_W-1:0] REM_LAST = CNT_W'(POS_W - 1);

    fstate_t            state_reg, state_next;
    logic [POS_W-1:0]   left_reg, left_next;
    logic [POS_W-1:0]   right_reg, right_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic               tick_reg, tick_next;
    logic [POS_W-1:0]   si_reg, si_next;
    logic [15:0]        sf_reg, sf_next;
    logic [SIZE_W-1:0]  rem_reg, rem_next;
    logic [POS_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               tgt_right_reg, tgt_right_next;

    logic               accept;
    logic               left_ge, right_ge;
    logic [SIZE_W-1:0]  half_sum, split_pos;
    logic [SIZE_W:0]    rem_try, rem_sub;
    logic [FRAC_W-1:0]  sf_al;
    logic [FRAC_W:0]    frac_sum;
    logic [SIZE_W-1:0]  si_cl, inc;
    logic [SIZE_W-1:0]  lsum, rsum, lwrap, rwrap;

    assign full   = (state_reg != F_IDLE) || iq_full;
    assign accept = push && !full;

    // wrap checks and stereo offset
    assign left_ge   = ({1'b0, left_reg} >= eff_size);
    assign right_ge  = ({1'b0, right_reg} >= eff_size);
    assign half_sum  = {1'b0, left_reg} + (eff_size >> 1);
    assign split_pos = (half_sum >= eff_size) ? half_sum - eff_size : half_sum;

    // one restoring remainder step
    assign rem_try = {rem_reg, div_reg[POS_W-1]};
    assign rem_sub = (rem_try >= {1'b0, eff_size}) ? rem_try - {1'b0, eff_size} : rem_try;

    // step fraction aligned to the fraction width
    if (FRAC_W >= 16)
    begin : g_sf_wide
        assign sf_al = FRAC_W'(sf_reg) << (FRAC_W - 16);
    end
    else
    begin : g_sf_narrow
        assign sf_al = sf_reg[15 -: FRAC_W];
    end

    // position advance
    assign frac_sum = {1'b0, frac_reg} + {1'b0, sf_al};
    assign si_cl    = ({1'b0, si_reg} >= eff_size) ? eff_size - SIZE_W'(1) : {1'b0, si_reg};
    assign inc      = si_cl + SIZE_W'(frac_sum[FRAC_W]);
    assign lsum     = {1'b0, left_reg} + inc;
    assign rsum     = {1'b0, right_reg} + inc;
    assign lwrap    = (lsum >= eff_size) ? lsum - eff_size : lsum;
    assign rwrap    = (rsum >= eff_size) ? rsum - eff_size : rsum;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        frac_next      = frac_reg;
        tick_next      = tick_reg;
        si_next        = si_reg;
        sf_next        = sf_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        tgt_right_next = tgt_right_reg;
        iq_push        = 1'b0;
        iq_op          = '0;
        iq_frac        = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_LOAD:
                        begin
                            iq_push       = 1'b1;
                            iq_op.is_tick = 1'b0;
                            iq_op.a       = table_addr;
                            iq_op.b       = $unsigned(table_data);
                        end
                        CMD_START:
                        begin
                            left_next  = start_pos;
                            tick_next  = 1'b0;
                            state_next = F_CHECK;
                        end
                        CMD_TICK:
                        begin
                            si_next    = step_int;
                            sf_next    = step_frac;
                            tick_next  = 1'b1;
                            state_next = F_CHECK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            F_CHECK:
            begin
                if (left_ge)
                begin
                    div_next       = left_reg;
                    rem_next       = '0;
                    cnt_next       = '0;
                    tgt_right_next = 1'b0;
                    state_next     = F_REM;
                end
                else if (tick_reg && right_ge)
                begin
                    div_next       = right_reg;
                    rem_next       = '0;
                    cnt_next       = '0;
                    tgt_right_next = 1'b1;
                    state_next     = F_REM;
                end
                else if (tick_reg)
                begin
                    state_next = F_STEP;
                end
                else
                begin
                    right_next = stereo ? split_pos[POS_W-1:0] : left_reg;
                    frac_next  = '0;
                    state_next = F_IDLE;
                end
            end
            F_REM:
            begin
                rem_next = rem_sub[SIZE_W-1:0];
                div_next = div_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == REM_LAST)
                begin
                    if (tgt_right_reg)
                    begin
                        right_next = rem_sub[POS_W-1:0];
                    end
                    else
                    begin
                        left_next = rem_sub[POS_W-1:0];
                    end
                    state_next = F_CHECK;
                end
            end
            F_STEP:
            begin
                if (!iq_full)
                begin
                    iq_push       = 1'b1;
                    iq_op.is_tick = 1'b1;
                    iq_op.a       = lwrap[POS_W-1:0];
                    iq_op.b       = rwrap[POS_W-1:0];
                    iq_frac       = frac_sum[FRAC_W-1:0];
                    left_next     = lwrap[POS_W-1:0];
                    right_next    = rwrap[POS_W-1:0];
                    frac_next     = frac_sum[FRAC_W-1:0];
                    state_next    = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control state and positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            frac_reg      <= '0;
            tick_reg      <= 1'b0;
            cnt_reg       <= '0;
            tgt_right_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            frac_reg      <= frac_next;
            tick_reg      <= tick_next;
            cnt_reg       <= cnt_next;
            tgt_right_reg <= tgt_right_next;
        end
    end

    // step and remainder payload
    always_ff @(posedge clk)
    begin
        si_reg  <= si_next;
        sf_reg  <= sf_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

// ----- design/swr_back.sv -----
// Back end: holds the wave table, fetches neighbor words and runs the
// linear or cubic interpolator for both channels. Uses swr_pkg.
module swr_back #(
    parameter int FRAC_W = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        iq_empty,
    input  swr_pkg::swr_op_t            iq_op,
    input  logic [FRAC_W-1:0]           iq_frac,
    output logic                        iq_pop,
    input  logic                        cubic_mode,
    input  logic [swr_pkg::SIZE_W-1:0]  eff_size,
    input  logic                        oq_full,
    output logic                        oq_push,
    output swr_pkg::swr_res_t           oq_res
);

    import swr_pkg::*;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_READ = 6'b000010,
        B_COEF = 6'b000100,
        B_MUL  = 6'b001000,
        B_ADD  = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    localparam int PROD_W = MULT_W + FRAC_W + 1;
    localparam int TAPS   = 8;
    localparam logic [2:0] LAST_CUBIC  = 3'd7;
    localparam logic [2:0] LAST_LINEAR = 3'd3;
    localparam logic [1:0] PH_B    = 2'd0;
    localparam logic [1:0] PH_C    = 2'd1;
    localparam logic [1:0] PH_LAST = 2'd2;

    bstate_t            state_reg, state_next;
    logic               cubic_reg, cubic_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [1:0]         ph_reg, ph_next;
    logic [POS_W-1:0]   left_reg, right_reg;
    logic [FRAC_W-1:0]  frac_reg;

    logic [SAMPLE_W-1:0]        wave_mem [TABLE_DEPTH];
    logic signed [SAMPLE_W-1:0] x_reg [TAPS];

    logic               mem_we;
    logic [POS_W-1:0]   mem_addr, rd_addr;
    logic               rd_ch;
    logic [1:0]         rd_k;
    logic [POS_W-1:0]   rd_pos;
    logic [SIZE_W-1:0]  asum, awrap;
    logic [2:0]         x_idx;
    logic [2:0]         read_last;

    logic signed [SAMPLE_W-1:0] sat_val [2];
    logic                       clip_lane [2];

    // neighbor address, wrapped modulo the table size
    assign rd_ch     = cubic_reg ? cnt_reg[2] : cnt_reg[1];
    assign rd_k      = cubic_reg ? cnt_reg[1:0] : {1'b0, cnt_reg[0]};
    assign rd_pos    = rd_ch ? right_reg : left_reg;
    assign asum      = {1'b0, rd_pos} + SIZE_W'(rd_k);
    assign awrap     = (asum >= eff_size) ? asum - eff_size : asum;
    assign rd_addr   = awrap[POS_W-1:0];
    assign x_idx     = {rd_ch, rd_k};
    assign read_last = cubic_reg ? LAST_CUBIC : LAST_LINEAR;

    // single port: load address while idle, else neighbor address
    assign mem_we   = (state_reg == B_IDLE) && !iq_empty && !iq_op.is_tick;
    assign mem_addr = (state_reg == B_IDLE) ? iq_op.a : rd_addr;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cubic_next = cubic_reg;
        cnt_next   = cnt_reg;
        ph_next    = ph_reg;
        iq_pop     = 1'b0;
        oq_push    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!iq_empty)
                begin
                    iq_pop = 1'b1;
                    if (iq_op.is_tick)
                    begin
                        cubic_next = cubic_mode;
                        cnt_next   = '0;
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == read_last)
                begin
                    state_next = B_COEF;
                end
            end
            B_COEF:
            begin
                ph_next    = PH_B;
                state_next = B_MUL;
            end
            B_MUL:
            begin
                state_next = B_ADD;
            end
            B_ADD:
            begin
                if (!cubic_reg || ph_reg == PH_LAST)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    ph_next    = ph_reg + 2'd1;
                    state_next = B_MUL;
                end
            end
            B_OUT:
            begin
                if (!oq_full)
                begin
                    oq_push    = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cubic_reg <= 1'b0;
            cnt_reg   <= '0;
            ph_reg    <= PH_B;
        end
        else
        begin
            state_reg <= state_next;
            cubic_reg <= cubic_next;
            cnt_reg   <= cnt_next;
            ph_reg    <= ph_next;
        end
    end

    // tick operands
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && !iq_empty && iq_op.is_tick)
        begin
            left_reg  <= iq_op.a;
            right_reg <= iq_op.b;
            frac_reg  <= iq_frac;
        end
    end

    // wave table with registered read into the tap registers
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wave_mem[mem_addr] <= iq_op.b;
        end
        if (state_reg == B_READ)
        begin
            x_reg[x_idx] <= $signed(wave_mem[mem_addr]);
        end
    end

    // one interpolator lane per channel
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [MULT_W-1:0] e_xm1, e_x0, e_x1, e_x2, d01;
        logic signed [MULT_W-1:0] coef_a, coef_b, coef_c, lin_d, flo;
        logic signed [PROD_W-1:0] rnd_lin, rnd_cub;
        logic signed [SUM_W-1:0]  y_lin, y_cub;
        logic signed [MULT_W-1:0] m_reg, b_reg, c_reg;
        logic signed [PROD_W-1:0] prod_reg;
        logic signed [SUM_W-1:0]  y_reg;

        assign e_xm1 = MULT_W'(x_reg[l * 4]);
        assign e_x0  = MULT_W'(x_reg[l * 4 + 1]);
        assign e_x1  = MULT_W'(x_reg[l * 4 + 2]);
        assign e_x2  = MULT_W'(x_reg[l * 4 + 3]);

        // doubled cubic coefficients, linear difference
        assign d01    = e_x0 - e_x1;
        assign coef_a = d01 + (d01 <<< 1) - e_xm1 + e_x2;
        assign coef_b = (e_x1 <<< 2) + (e_xm1 <<< 1) - ((e_x0 <<< 2) + e_x0) - e_x2;
        assign coef_c = e_x1 - e_xm1;
        assign lin_d  = e_x0 - e_xm1;

        // floor and rounding of the scaled product
        assign flo     = MULT_W'(prod_reg >>> FRAC_W);
        assign rnd_lin = prod_reg + (PROD_W'(1) <<< (FRAC_W - 1));
        assign rnd_cub = prod_reg + (PROD_W'(1) <<< FRAC_W);
        assign y_lin   = SUM_W'(x_reg[l * 4]) + SUM_W'(rnd_lin >>> FRAC_W);
        assign y_cub   = SUM_W'(x_reg[l * 4 + 1]) + SUM_W'(rnd_cub >>> (FRAC_W + 1));

        always_ff @(posedge clk)
        begin
            case (state_reg)
                B_COEF:
                begin
                    m_reg <= cubic_reg ? coef_a : lin_d;
                    b_reg <= coef_b;
                    c_reg <= coef_c;
                end
                B_MUL:
                begin
                    prod_reg <= m_reg * $signed({1'b0, frac_reg});
                end
                B_ADD:
                begin
                    if (!cubic_reg)
                    begin
                        y_reg <= y_lin;
                    end
                    else if (ph_reg == PH_B)
                    begin
                        m_reg <= flo + b_reg;
                    end
                    else if (ph_reg == PH_C)
                    begin
                        m_reg <= flo + c_reg;
                    end
                    else
                    begin
                        y_reg <= y_cub;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // saturate to the sample width
        assign clip_lane[l] = (y_reg > Y_MAX) || (y_reg < Y_MIN);
        assign sat_val[l]   = (y_reg > Y_MAX) ? SAMPLE_W'(Y_MAX) :
                              (y_reg < Y_MIN) ? SAMPLE_W'(Y_MIN) : SAMPLE_W'(y_reg);
    end

    assign oq_res.left    = sat_val[0];
    assign oq_res.right   = sat_val[1];
    assign oq_res.clipped = clip_lane[0] || clip_lane[1];

endmodule

// ----- design/stereo_wavetable_resampler.sv -----
// Top level of the stereo wavetable resampler: config registers, front end,
// op queue, back end and result queue. Uses swr_pkg and all swr_ modules.
//
// Usage: items enter on push/full, results leave on empty/pop, both sides
// behave like a queue. A load word (cmd 0) writes one table entry, a start
// word (cmd 1) sets the read positions and clears the fraction, a tick word
// (cmd 2) advances the positions and yields one stereo result word; other
// codes are taken and dropped. Registers sit on the APB port at 0x0
// (interpolation mode), 0x4 (table size) and 0x8 (stereo mode).
// Throughput: the front takes a load every cycle while the op queue has room;
// a tick passes its check and step states, a start its check state, plus a
// bit-serial remainder when the start position is not below the size.
// The back runs each tick through table reads, coefficients and multiply-add,
// its cost set by the single-port table (2 or 4 reads per channel) and the
// three multiply-add passes of the cubic form; a load costs it one table write.
// A tick waits for a bit-serial remainder per position to reduce after the size shrank.
// Reset clears positions, fraction, queues and registers; table contents
// are kept. When the receiver stalls, two result words wait in the result
// queue, four ops in the op queue, then full rises.
module stereo_wavetable_resampler #(
    parameter int FRAC_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  swr_pkg::cmd_t               cmd,
    input  logic [swr_pkg::POS_W-1:0]   table_addr,
    input  logic signed [15:0]          table_data,
    input  logic [swr_pkg::POS_W-1:0]   start_pos,
    input  logic [swr_pkg::POS_W-1:0]   step_int,
    input  logic [15:0]                 step_frac,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [15:0]          left_sample,
    output logic signed [15:0]          right_sample,
    output logic                        clipped
);

    import swr_pkg::*;

    localparam int OP_W  = $bits(swr_op_t) + FRAC_WIDTH;
    localparam int RES_W = $bits(swr_res_t);

    logic               interp_reg, interp_next;
    logic [SIZE_W-1:0]  size_raw_reg, size_raw_next;
    logic [SIZE_W-1:0]  eff_size_reg, eff_size_next;
    logic               stereo_reg, stereo_next;
    logic               cfg_we;
    reg_idx_t           cfg_idx;
    logic [SIZE_W-1:0]  size_wr;

    logic                   iq_push, iq_full, iq_pop, iq_empty;
    swr_op_t                fe_op, be_op;
    logic [FRAC_WIDTH-1:0]  fe_frac, be_frac;
    logic [OP_W-1:0]        iq_rdata;
    logic                   oq_push, oq_full;
    swr_res_t               be_res, oq_res;
    logic [RES_W-1:0]       oq_rdata;

    // config port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];
    assign size_wr = pwdata[SIZE_W-1:0];

    always_comb
    begin
        interp_next   = interp_reg;
        size_raw_next = size_raw_reg;
        eff_size_next = eff_size_reg;
        stereo_next   = stereo_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_INTERP:
                begin
                    interp_next = pwdata[0];
                end
                REG_SIZE:
                begin
                    size_raw_next = size_wr;
                    eff_size_next = (size_wr < SIZE_MIN) ? SIZE_MIN :
                                    (size_wr > SIZE_MAX) ? SIZE_MAX : size_wr;
                end
                REG_STEREO:
                begin
                    stereo_next = pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg   <= 1'b0;
            size_raw_reg <= SIZE_MAX;
            eff_size_reg <= SIZE_MAX;
            stereo_reg   <= 1'b0;
        end
        else
        begin
            interp_reg   <= interp_next;
            size_raw_reg <= size_raw_next;
            eff_size_reg <= eff_size_next;
            stereo_reg   <= stereo_next;
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_INTERP: prdata = 32'(interp_reg);
            REG_SIZE:   prdata = 32'(size_raw_reg);
            REG_STEREO: prdata = 32'(stereo_reg);
            default:    prdata = '0;
        endcase
    end

    // front end
    swr_front #(
        .FRAC_W (FRAC_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .table_addr (table_addr),
        .table_data (table_data),
        .start_pos  (start_pos),
        .step_int   (step_int),
        .step_frac  (step_frac),
        .stereo     (stereo_reg),
        .eff_size   (eff_size_reg),
        .iq_full    (iq_full),
        .iq_push    (iq_push),
        .iq_op      (fe_op),
        .iq_frac    (fe_frac)
    );

    // op queue between front and back
    swr_queue #(
        .WIDTH (OP_W),
        .DEPTH (4)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (iq_push),
        .wdata ({fe_op, fe_frac}),
        .full  (iq_full),
        .pop   (iq_pop),
        .rdata (iq_rdata),
        .empty (iq_empty)
    );

    assign {be_op, be_frac} = iq_rdata;

    // back end
    swr_back #(
        .FRAC_W (FRAC_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .iq_empty   (iq_empty),
        .iq_op      (be_op),
        .iq_frac    (be_frac),
        .iq_pop     (iq_pop),
        .cubic_mode (interp_reg),
        .eff_size   (eff_size_reg),
        .oq_full    (oq_full),
        .oq_push    (oq_push),
        .oq_res     (be_res)
    );

    // result queue
    swr_queue #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (be_res),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign oq_res       = oq_rdata;
    assign left_sample  = oq_res.left;
    assign right_sample = oq_res.right;
    assign clipped      = oq_res.clipped;

`ifndef SYNTHESIS
    // the back never drops a result into a full result queue
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> !oq_full)
        else $error("result pushed into full queue");

    // the front never drops an op into a full op queue
    a_op_room: assert property (@(posedge clk) disable iff (!rst_n)
        iq_push |-> !iq_full)
        else $error("op pushed into full queue");

    // the table size in use stays within its clamp bounds
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        (eff_size_reg >= SIZE_MIN) && (eff_size_reg <= SIZE_MAX))
        else $error("table size out of range");

    // a table size write lands in the register on the next edge
    a_size_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_idx == REG_SIZE) |=> (size_raw_reg == $past(size_wr)))
        else $error("table size write lost");
`endif

endmodule

// ----- bench/stereo_wavetable_resampler_test.sv -----
// Self-checking bench for the stereo wavetable resampler: a directed script and
// randomized phases, each result word checked against a local model or a known value.
// Depends on swr_pkg and the stereo_wavetable_resampler top level.
module stereo_wavetable_resampler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swr_pkg::*;

    localparam int IDLE_PCT      = 27;
    localparam int SETTLE_CYCLES = 128;
    localparam int FRAC_W        = 16;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 151;
    localparam cmd_t CMD_UNUSED  = 2'd3;

    // table size register values for the first phases, clamped ones included
    localparam int unsigned SIZE_PICKS [8] = '{4, 65536, 0, 131071, 5, 3, 65537, 7};

    // one line of the directed script: a register write or an input word
    typedef struct packed {
        logic        is_reg;
        reg_idx_t    idx;
        logic [31:0] value;
        cmd_t        op;
        logic [15:0] addr;
        logic [15:0] data;
        logic [15:0] spos;
        logic [15:0] sint;
        logic [15:0] sfrac;
        logic        typed;
        swr_res_t    want;
    } dir_row_t;

    // dut ports
    logic               clk;
    logic               rst_n      = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [3:0]         paddr      = '0;
    logic [31:0]        pwdata     = '0;
    wire  [31:0]        prdata;
    wire                pready;
    logic               push       = 1'b0;
    wire                full;
    cmd_t               cmd        = CMD_LOAD;
    logic [15:0]        table_addr = '0;
    logic signed [15:0] table_data = '0;
    logic [15:0]        start_pos  = '0;
    logic [15:0]        step_int   = '0;
    logic [15:0]        step_frac  = '0;
    wire                empty;
    logic               pop        = 1'b0;
    wire signed [15:0]  left_sample;
    wire signed [15:0]  right_sample;
    wire                clipped;

    // model state: table, written marks, read positions, shared fraction, registers
    logic signed [15:0] wave_mem [TABLE_DEPTH];
    bit                 written [TABLE_DEPTH];
    int unsigned        left_at   = 0;
    int unsigned        right_at  = 0;
    int unsigned        frac_acc  = 0;
    logic               cubic_on  = 1'b0;
    logic               stereo_on = 1'b0;
    logic [16:0]        size_reg  = SIZE_MAX;

    // bookkeeping
    swr_res_t expected_words [$];
    int       errors          = 0;
    int       words_taken     = 0;
    int       results_checked = 0;
    int       clip_results    = 0;
    int       reg_writes      = 0;
    bit       steady          = 1'b0;

    stereo_wavetable_resampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .table_addr   (table_addr),
        .table_data   (table_data),
        .start_pos    (start_pos),
        .step_int     (step_int),
        .step_frac    (step_frac),
        .empty        (empty),
        .pop          (pop),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .clipped      (clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // table size in use, clamped to the legal range
    function automatic int unsigned used_size();
        int unsigned s;
        s = size_reg;
        if (s < SIZE_MIN)
            s = SIZE_MIN;
        if (s > SIZE_MAX)
            s = SIZE_MAX;
        return s;
    endfunction

    // neighbour read, wrapping at the table size
    function automatic longint tap(int unsigned p, int unsigned k, int unsigned size);
        return longint'(wave_mem[(p + k) % size]);
    endfunction

    // linear or four-point cubic interpolation at position p, fraction f
    function automatic longint blend(int unsigned p, int unsigned size, longint f);
        longint s0, s1, xm1, x0, x1, x2, a, b, c, h;
        if (!cubic_on)
        begin
            s0 = tap(p, 0, size);
            s1 = tap(p, 1, size);
            return ((s0 <<< FRAC_W) + (s1 - s0) * f + (longint'(1) <<< (FRAC_W - 1)))
                   >>> FRAC_W;
        end
        xm1 = tap(p, 0, size);
        x0  = tap(p, 1, size);
        x1  = tap(p, 2, size);
        x2  = tap(p, 3, size);
        // coefficients kept at twice their usual size
        a = 3 * (x0 - x1) - xm1 + x2;
        b = 4 * x1 + 2 * xm1 - 5 * x0 - x2;
        c = x1 - xm1;
        h = ((a * f) >>> FRAC_W) + b;
        h = ((h * f) >>> FRAC_W) + c;
        return x0 + ((h * f + (longint'(1) <<< FRAC_W)) >>> (FRAC_W + 1));
    endfunction

    function automatic logic signed [15:0] saturate(longint y);
        if (y > Y_MAX)
            return 16'sh7FFF;
        if (y < Y_MIN)
            return 16'sh8000;
        return 16'(y);
    endfunction

    // apply one accepted word to the model; returns 1 when it yields a result word
    function automatic bit track_word(cmd_t op, logic [15:0] addr, data, spos, sint,
                                      sfrac, output swr_res_t res);
        int unsigned size, si, carry;
        longint      yl, yr;
        size = used_size();
        res  = '0;
        if (op == CMD_LOAD)
        begin
            wave_mem[addr] = data;
            written[addr]  = 1'b1;
        end
        else if (op == CMD_START)
        begin
            left_at  = spos % size;
            right_at = stereo_on ? (left_at + size / 2) % size : left_at;
            frac_acc = 0;
        end
        else if (op == CMD_TICK)
        begin
            si = sint;
            if (si >= size)
                si = size - 1;
            // positions may be stale after the size shrank
            left_at  = left_at % size;
            right_at = right_at % size;
            frac_acc = frac_acc + sfrac;
            carry    = frac_acc >> FRAC_W;
            frac_acc = frac_acc & 32'hFFFF;
            left_at  = left_at + si + carry;
            if (left_at >= size)
                left_at = left_at - size;
            right_at = right_at + si + carry;
            if (right_at >= size)
                right_at = right_at - size;
            yl = blend(left_at, size, frac_acc);
            yr = blend(right_at, size, frac_acc);
            res.left    = saturate(yl);
            res.right   = saturate(yr);
            res.clipped = (yl > Y_MAX) || (yl < Y_MIN) || (yr > Y_MAX) || (yr < Y_MIN);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // random sample, full scale now and then to provoke saturation
    function automatic logic [15:0] pick_sample();
        if ($urandom_range(9) < 2)
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        return 16'($urandom);
    endfunction

    function automatic dir_row_t reg_row(reg_idx_t idx, logic [31:0] value);
        dir_row_t r;
        r        = '0;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.value  = value;
        return r;
    endfunction

    function automatic dir_row_t word_row(cmd_t op, logic [15:0] addr, data, spos, sint,
                                          sfrac);
        dir_row_t r;
        r       = '0;
        r.op    = op;
        r.addr  = addr;
        r.data  = data;
        r.spos  = spos;
        r.sint  = sint;
        r.sfrac = sfrac;
        return r;
    endfunction

    // tick whose result is known by inspection
    function automatic dir_row_t known_tick(logic [15:0] sint, sfrac,
                                            logic signed [15:0] l, r, logic c);
        dir_row_t row;
        row              = word_row(CMD_TICK, 16'h0, 16'h0, 16'h0, sint, sfrac);
        row.typed        = 1'b1;
        row.want.left    = l;
        row.want.right   = r;
        row.want.clipped = c;
        return row;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 30)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // offer one word on the push side and wait until it is taken
    task automatic offer_word(cmd_t op, logic [15:0] addr, data, spos, sint, sfrac,
                              bit typed = 1'b0, swr_res_t want = '0);
        swr_res_t res;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        cmd        <= op;
        table_addr <= addr;
        table_data <= data;
        start_pos  <= spos;
        step_int   <= sint;
        step_frac  <= sfrac;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_taken++;
        if (track_word(op, addr, data, spos, sint, sfrac, res))
            expected_words.push_back(typed ? want : res);
    endtask

    // write every table entry that the coming tick reads and nobody wrote yet
    task automatic fill_taps(logic [15:0] sint, sfrac);
        int unsigned size, si, carry, lp, rp, taps, spot;
        size  = used_size();
        si    = sint;
        if (si >= size)
            si = size - 1;
        carry = (frac_acc + sfrac) >> FRAC_W;
        lp    = (left_at % size + si + carry) % size;
        rp    = (right_at % size + si + carry) % size;
        taps  = cubic_on ? 4 : 2;
        for (int k = 0; k < 2 * taps; k++)
        begin
            spot = (((k < taps) ? lp : rp) + k % taps) % size;
            if (!written[spot])
                offer_word(CMD_LOAD, 16'(spot), pick_sample(), 16'($urandom),
                           16'($urandom), 16'($urandom));
        end
    endtask

    // push one word; a tick first gets the entries it reads written
    task automatic push_word(cmd_t op, logic [15:0] addr, data, spos, sint, sfrac,
                             bit typed = 1'b0, swr_res_t want = '0);
        if (op == CMD_TICK)
            fill_taps(sint, sfrac);
        offer_word(op, addr, data, spos, sint, sfrac, typed, want);
    endtask

    // drain all expected words, then let loads and starts still in flight finish
    task automatic settle();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_INTERP)
            cubic_on = value[0];
        else if (idx == REG_SIZE)
            size_reg = value[16:0];
        else if (idx == REG_STEREO)
            stereo_on = value[0];
        reg_writes++;
    endtask

    // result side: check each popped word, then decide the next pop
    always @(posedge clk)
    begin : drain
        swr_res_t w;
        if (rst_n && pop && !empty)
        begin
            results_checked++;
            if (expected_words.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
            end
            else
            begin
                w = expected_words.pop_front();
                if (w.clipped)
                    clip_results++;
                if (left_sample !== w.left)
                    report_mismatch($sformatf("left_sample %0d, expected %0d",
                                              left_sample, w.left));
                if (right_sample !== w.right)
                    report_mismatch($sformatf("right_sample %0d, expected %0d",
                                              right_sample, w.right));
                if (clipped !== w.clipped)
                    report_mismatch($sformatf("clipped %0b, expected %0b",
                                              clipped, w.clipped));
            end
        end
        pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : main
        dir_row_t    script [$];
        dir_row_t    row;
        int unsigned size, phase_start, pick, v;
        logic [15:0] spos, addr, sint, sfrac;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script: four-entry table of full-scale alternating samples
        script.push_back(reg_row(REG_SIZE, 32'd4));
        script.push_back(reg_row(REG_INTERP, 32'd0));
        script.push_back(reg_row(REG_STEREO, 32'd0));
        script.push_back(word_row(CMD_LOAD, 16'd0, 16'h7FFF, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_LOAD, 16'd1, 16'h8000, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_LOAD, 16'd2, 16'h7FFF, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_LOAD, 16'd3, 16'h8000, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_START, 16'h0, 16'h0, 16'd0, 16'h0, 16'h0));
        script.push_back(known_tick(16'd0, 16'h0, 32767, 32767, 1'b0));
        script.push_back(known_tick(16'd1, 16'h0, -32768, -32768, 1'b0));
        // integer step far above the size gets clamped to size - 1
        script.push_back(known_tick(16'hFFFF, 16'h0, 32767, 32767, 1'b0));
        script.push_back(word_row(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'd0, 16'hFFFF));
        // fraction carry moves both positions by one
        script.push_back(known_tick(16'd0, 16'h0001, -32768, -32768, 1'b0));
        // stereo start beyond the size: left wraps, right half a table away
        script.push_back(reg_row(REG_STEREO, 32'd1));
        script.push_back(word_row(CMD_START, 16'h0, 16'h0, 16'd5, 16'h0, 16'h0));
        script.push_back(known_tick(16'd0, 16'h0, -32768, -32768, 1'b0));
        // cubic at zero fraction gives the second tap, neighbours wrapping
        script.push_back(reg_row(REG_INTERP, 32'd1));
        script.push_back(known_tick(16'd0, 16'h0, 32767, 32767, 1'b0));
        // plateau shape overshoots high, then low
        script.push_back(word_row(CMD_LOAD, 16'd0, 16'h0000, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_LOAD, 16'd1, 16'h7FFF, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_LOAD, 16'd3, 16'h0000, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_START, 16'h0, 16'h0, 16'd0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'd0, 16'h8000));
        script.push_back(word_row(CMD_LOAD, 16'd1, 16'h8000, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_LOAD, 16'd2, 16'h8000, 16'h0, 16'h0, 16'h0));
        script.push_back(word_row(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'd0, 16'h0));
        // unused command code is dropped
        script.push_back(word_row(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF));
        // oversized register clamps to full depth, then zero clamps to four
        script.push_back(reg_row(REG_SIZE, 32'd131071));
        script.push_back(word_row(CMD_START, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0));
        script.push_back(word_row(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF));
        script.push_back(reg_row(REG_SIZE, 32'd0));
        script.push_back(word_row(CMD_TICK, 16'h0, 16'h0, 16'h0, 16'd0, 16'h0));

        foreach (script[i])
        begin
            row = script[i];
            if (row.is_reg)
                write_reg(row.idx, row.value);
            else
                push_word(row.op, row.addr, row.data, row.spos, row.sint, row.sfrac,
                          row.typed, row.want);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 8)
                v = SIZE_PICKS[ph];
            else if ($urandom_range(3) == 0)
                v = $urandom_range(131071);
            else
                v = $urandom_range(48, 4);
            write_reg(REG_SIZE, ($urandom & 32'hFFFE_0000) | v);
            write_reg(REG_INTERP, ($urandom & 32'hFFFF_FFFE) | (ph & 1));
            write_reg(REG_STEREO, ($urandom & 32'hFFFF_FFFE) | ((ph >> 1) & 1));
            steady = (ph == PHASES / 2);
            phase_start = words_taken;
            while (words_taken - phase_start < PHASE_WORDS)
            begin
                size = used_size();
                pick = $urandom_range(99);
                if (words_taken == phase_start || pick < 8)
                begin
                    spos = ($urandom_range(9) < 7) ? 16'($urandom_range(size - 1))
                                                   : 16'($urandom);
                    push_word(CMD_START, 16'($urandom), 16'($urandom), spos,
                              16'($urandom), 16'($urandom));
                end
                else if (pick < 24)
                begin
                    addr = ($urandom_range(9) < 8) ? 16'($urandom_range(size - 1))
                                                   : 16'($urandom);
                    push_word(CMD_LOAD, addr, pick_sample(), 16'($urandom),
                              16'($urandom), 16'($urandom));
                end
                else if (pick < 27)
                begin
                    push_word(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 60)
                        sint = 16'($urandom_range(3));
                    else if (pick < 85)
                        sint = 16'($urandom_range(size - 1));
                    else
                        sint = 16'($urandom);
                    pick = $urandom_range(99);
                    if (pick < 10)
                        sfrac = 16'h0000;
                    else if (pick < 20)
                        sfrac = 16'hFFFF;
                    else
                        sfrac = 16'($urandom);
                    push_word(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                              sint, sfrac);
                end
            end
        end
        steady = 1'b0;

        settle();
        $display("%0d words taken over a directed script and %0d random phases,"
                 , words_taken, PHASES);
        $display("%0d register writes, %0d result words checked, %0d of them saturated",
                 reg_writes, results_checked, clip_results);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
